// ===== src/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg: shared definitions for the priority task table
// Sizes, command and status codes, and the records that travel along the
// slot chain and from the control logic to the slots.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int NUM_SLOTS     = 64;
	localparam int ID_BITS       = 16;
	localparam int PRIORITY_BITS = 32;
	localparam int USER_BITS     = 16;
	localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_EDIT   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EXEC   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Record handed from one slot cell to the next during a scan.
	typedef struct packed {
		logic                     go;
		logic                     match_hit;
		logic [SLOT_W-1:0]        match_idx;
		logic                     free_hit;
		logic [SLOT_W-1:0]        free_idx;
		logic                     best_hit;
		logic [SLOT_W-1:0]        best_idx;
		logic [PRIORITY_BITS-1:0] best_prio;
		logic [ID_BITS-1:0]       best_task;
		logic [USER_BITS-1:0]     best_user;
	} scan_t;

	// Update of one slot, broadcast to all cells.
	typedef struct packed {
		logic                     wr_all;
		logic                     wr_prio;
		logic                     clr;
		logic [SLOT_W-1:0]        idx;
		logic [ID_BITS-1:0]       task_id;
		logic [USER_BITS-1:0]     user_id;
		logic [PRIORITY_BITS-1:0] prio;
	} apply_t;

endpackage

// ===== src/ptt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_cell: one slot of the task table
// Holds one entry, folds it into the scan record passing by and hands the
// record on to the next cell through its own register.
// ----------------------------------------------------------------------------
module ptt_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ptt_pkg::SLOT_W-1:0]        slot_idx,
	input  logic [ptt_pkg::ID_BITS-1:0]       key_id,
	input  ptt_pkg::scan_t                    scan_in,
	input  ptt_pkg::apply_t                   apply,
	output ptt_pkg::scan_t                    scan_out
);

	logic                                valid_q;
	logic [ptt_pkg::ID_BITS-1:0]         task_q;
	logic [ptt_pkg::USER_BITS-1:0]       user_q;
	logic [ptt_pkg::PRIORITY_BITS-1:0]   prio_q;
	ptt_pkg::scan_t                      scan_nxt;
	ptt_pkg::scan_t                      scan_q;
	logic                                sel;

	assign sel = (apply.idx == slot_idx);

	always_comb begin
		scan_nxt = scan_in;
		if (!scan_in.match_hit && valid_q && (task_q == key_id)) begin
			scan_nxt.match_hit = 1'b1;
			scan_nxt.match_idx = slot_idx;
		end
		if (!scan_in.free_hit && !valid_q) begin
			scan_nxt.free_hit = 1'b1;
			scan_nxt.free_idx = slot_idx;
		end
		if (valid_q && (!scan_in.best_hit || (prio_q > scan_in.best_prio) ||
				((prio_q == scan_in.best_prio) && (task_q > scan_in.best_task)))) begin
			scan_nxt.best_hit  = 1'b1;
			scan_nxt.best_idx  = slot_idx;
			scan_nxt.best_prio = prio_q;
			scan_nxt.best_task = task_q;
			scan_nxt.best_user = user_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			scan_q <= scan_nxt;
			if (sel && apply.wr_all) begin
				valid_q <= 1'b1;
			end else if (sel && apply.clr) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Entry contents are only read while the valid bit is set.
	always_ff @(posedge clk) begin
		if (sel && apply.wr_all) begin
			task_q <= apply.task_id;
			user_q <= apply.user_id;
			prio_q <= apply.prio;
		end else if (sel && apply.wr_prio) begin
			prio_q <= apply.prio;
		end
	end

	assign scan_out = scan_q;

endmodule

// ===== src/priority_task_table.sv =====
`timescale 1ns / 1ps
// Flow: an accepted command is held in the command registers and the start flag launches a scan
// record, which walks the slot cells in order into fin_q; the finish step then loads the result.
// No new command is taken until the finish step is done and control is back in idle.
// A new command may be taken while the previous result still waits at the output register.
// Reset: arst_n clears all slot valid bits, the scan chain and the control state at once.
// No clearing pass is needed; the table is empty and ready right after reset.
// ----------------------------------------------------------------------------
// priority_task_table: indexed priority queue of tasks
// A chain of slot cells holds the entries. Each command launches a scan
// record at the head of the chain; every cell folds its own entry into the
// record (id match, first free slot, best entry) and passes it on. When the
// record leaves the tail, the control logic decides the outcome, writes at
// most one slot through a broadcast update and loads the result register.
// ----------------------------------------------------------------------------
module priority_task_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] task_id,
	input  logic [15:0] user_id,
	input  logic [31:0] priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] top_user
);

	ptt_pkg::state_t                   state_q;
	ptt_pkg::state_t                   state_nxt;

	// Command registers, held for the whole scan.
	ptt_pkg::cmd_t                     cmd_q;
	logic [ptt_pkg::ID_BITS-1:0]       id_q;
	logic [ptt_pkg::USER_BITS-1:0]     user_q;
	logic [ptt_pkg::PRIORITY_BITS-1:0] prio_q;
	logic                              start_q;

	// Scan chain: entry 0 is the launch point, entry NUM_SLOTS the tail.
	ptt_pkg::scan_t                    scan_chain [ptt_pkg::NUM_SLOTS+1];
	logic [ptt_pkg::NUM_SLOTS-1:0]     go_vec;
	ptt_pkg::scan_t                    fin_q;

	ptt_pkg::apply_t                   apply;
	ptt_pkg::status_t                  res_status;
	logic [ptt_pkg::USER_BITS-1:0]     res_user;

	logic                              out_valid_q;
	ptt_pkg::status_t                  status_q;
	logic [ptt_pkg::USER_BITS-1:0]     top_user_q;

	logic                              in_fire;
	logic                              finish_fire;
	logic                              tail_go;

	assign in_fire = in_valid && in_ready;
	assign tail_go = scan_chain[ptt_pkg::NUM_SLOTS].go;

	// The head record starts empty; only its go bit marks a live scan.
	always_comb begin
		scan_chain[0]    = '0;
		scan_chain[0].go = start_q;
	end

	for (genvar g = 0; g < ptt_pkg::NUM_SLOTS; g++) begin : g_slot
		ptt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_idx (ptt_pkg::SLOT_W'(g)),
			.key_id   (id_q),
			.scan_in  (scan_chain[g]),
			.apply    (apply),
			.scan_out (scan_chain[g+1])
		);
		assign go_vec[g] = scan_chain[g+1].go;
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_nxt = ptt_pkg::ST_SCAN;
				end
			end
			ptt_pkg::ST_SCAN: begin
				if (tail_go) begin
					state_nxt = ptt_pkg::ST_FINISH;
				end
			end
			ptt_pkg::ST_FINISH: begin
				if (finish_fire) begin
					state_nxt = ptt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ptt_pkg::ST_IDLE;
		endcase
	end

	// State-machine outputs. The finish step waits only if the previous
	// result has not been taken yet.
	always_comb begin
		in_ready    = 1'b0;
		finish_fire = 1'b0;
		unique case (state_q)
			ptt_pkg::ST_IDLE:   in_ready = 1'b1;
			ptt_pkg::ST_SCAN:   in_ready = 1'b0;
			ptt_pkg::ST_FINISH: finish_fire = !out_valid_q || out_ready;
			default:            in_ready = 1'b0;
		endcase
	end

	// Outcome of the command from the record that left the tail. The slot
	// update is only driven in the cycle the result is loaded.
	always_comb begin
		apply         = '0;
		apply.task_id = id_q;
		apply.user_id = user_q;
		apply.prio    = prio_q;
		res_status    = ptt_pkg::STAT_OK;
		res_user      = '0;
		unique case (cmd_q)
			ptt_pkg::CMD_ADD: begin
				// An existing id is overwritten in place; otherwise the
				// lowest free slot takes it.
				if (fin_q.match_hit) begin
					apply.wr_all = finish_fire;
					apply.idx    = fin_q.match_idx;
				end else if (fin_q.free_hit) begin
					apply.wr_all = finish_fire;
					apply.idx    = fin_q.free_idx;
				end else begin
					res_status = ptt_pkg::STAT_FULL;
				end
			end
			ptt_pkg::CMD_EDIT: begin
				if (fin_q.match_hit) begin
					apply.wr_prio = finish_fire;
					apply.idx     = fin_q.match_idx;
				end else begin
					res_status = ptt_pkg::STAT_NOT_FOUND;
				end
			end
			ptt_pkg::CMD_REMOVE: begin
				if (fin_q.match_hit) begin
					apply.clr = finish_fire;
					apply.idx = fin_q.match_idx;
				end else begin
					res_status = ptt_pkg::STAT_NOT_FOUND;
				end
			end
			ptt_pkg::CMD_EXEC: begin
				// The best entry is removed and its user reported; an empty
				// table reports not found with a zero user.
				if (fin_q.best_hit) begin
					apply.clr = finish_fire;
					apply.idx = fin_q.best_idx;
					res_user  = fin_q.best_user;
				end else begin
					res_status = ptt_pkg::STAT_NOT_FOUND;
				end
			end
			default: res_status = ptt_pkg::STAT_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptt_pkg::ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= in_fire;
			if (finish_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= ptt_pkg::cmd_t'(cmd);
			id_q   <= ptt_pkg::ID_BITS'(task_id);
			user_q <= ptt_pkg::USER_BITS'(user_id);
			prio_q <= ptt_pkg::PRIORITY_BITS'(priority_req);
		end
		if (tail_go) begin
			fin_q <= scan_chain[ptt_pkg::NUM_SLOTS];
		end
		if (finish_fire) begin
			status_q   <= res_status;
			top_user_q <= res_user;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = 2'(status_q);
	assign top_user  = 16'(top_user_q);

	// Only one scan record is ever in flight along the chain.
	a_single_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({go_vec, start_q}))
		else $error("more than one scan record in the slot chain");

	// A record leaving the tail always moves the control into the finish step.
	a_tail_finish: assert property (@(posedge clk) disable iff (!arst_n)
		tail_go |=> (state_q == ptt_pkg::ST_FINISH))
		else $error("scan completed outside of a scan");

	// At most one kind of slot update is driven at a time.
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({apply.wr_all, apply.wr_prio, apply.clr}))
		else $error("conflicting slot updates");

	// A result only appears as the finish step of a command.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ptt_pkg::ST_FINISH))
		else $error("result produced without a finished command");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for priority_task_table
// Drives add, edit, remove and execute-top commands through the valid/ready
// command channel and keeps a shadow copy of the task slots. Each command
// updates the shadow copy at the moment it is accepted, and the expected
// status and user are queued. Every result transaction is checked against
// the oldest queued outcome. Both channels idle at random, and one phase
// holds the result channel off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

	// The drain wait at the end allows two full scans for any late or extra result.
	localparam int RESET_CYCLES   = 7;
	localparam int DRAIN_CYCLES   = 2 * (ptt_pkg::NUM_SLOTS + 3);
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOT_IDS        = 32;

	// What one command is expected to report.
	typedef struct {
		ptt_pkg::status_t              st;
		logic [ptt_pkg::USER_BITS-1:0] user;
	} outcome_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd          = ptt_pkg::CMD_ADD;
	logic [15:0] task_id      = '0;
	logic [15:0] user_id      = '0;
	logic [31:0] priority_req = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  status;
	logic [15:0] top_user;

	// Shadow copy of the slots. Only entries whose valid bit is set are ever
	// read, so the other stores need no reset value.
	logic                              shadow_valid [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::ID_BITS-1:0]       shadow_id    [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::USER_BITS-1:0]     shadow_user  [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::PRIORITY_BITS-1:0] shadow_prio  [ptt_pkg::NUM_SLOTS];
	int                                shadow_count = 0;

	outcome_t    awaited_outcomes [$];
	logic [15:0] hot_ids [HOT_IDS];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          no_idle        = 1'b0;
	bit          hold_requested = 1'b0;

	priority_task_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.task_id      (task_id),
		.user_id      (user_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.top_user     (top_user)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
		end
	end

	// Apply one accepted command to the shadow slots and queue the outcome.
	// A single pass finds the slot that holds the id, the lowest free slot
	// and the best entry: highest priority, ties going to the larger id.
	task automatic update_shadow_table(input ptt_pkg::cmd_t op, input logic [15:0] id_in,
			input logic [15:0] user_in, input logic [31:0] prio_in);
		int       hit;
		int       free_slot;
		int       best;
		outcome_t res;
		hit       = -1;
		free_slot = -1;
		best      = -1;
		res.st    = ptt_pkg::STAT_OK;
		res.user  = '0;
		for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
			if (shadow_valid[i] && shadow_id[i] == id_in && hit < 0) begin
				hit = i;
			end
			if (!shadow_valid[i] && free_slot < 0) begin
				free_slot = i;
			end
			if (shadow_valid[i] && (best < 0 || shadow_prio[i] > shadow_prio[best] ||
					(shadow_prio[i] == shadow_prio[best] &&
					 shadow_id[i] > shadow_id[best]))) begin
				best = i;
			end
		end
		case (op)
			ptt_pkg::CMD_ADD: begin
				// A present id is overwritten in place; a new one needs a free slot.
				if (hit < 0) begin
					hit = free_slot;
					if (hit >= 0) begin
						shadow_count++;
					end
				end
				if (hit < 0) begin
					res.st = ptt_pkg::STAT_FULL;
				end else begin
					shadow_valid[hit] = 1'b1;
					shadow_id[hit]    = id_in;
					shadow_user[hit]  = user_in;
					shadow_prio[hit]  = prio_in;
				end
			end
			ptt_pkg::CMD_EDIT: begin
				if (hit < 0) begin
					res.st = ptt_pkg::STAT_NOT_FOUND;
				end else begin
					shadow_prio[hit] = prio_in;
				end
			end
			ptt_pkg::CMD_REMOVE: begin
				if (hit < 0) begin
					res.st = ptt_pkg::STAT_NOT_FOUND;
				end else begin
					shadow_valid[hit] = 1'b0;
					shadow_count--;
				end
			end
			default: begin
				// Execute-top on an empty table reports not found with user zero.
				if (best < 0) begin
					res.st = ptt_pkg::STAT_NOT_FOUND;
				end else begin
					res.user           = shadow_user[best];
					shadow_valid[best] = 1'b0;
					shadow_count--;
				end
			end
		endcase
		awaited_outcomes.push_back(res);
	endtask

	// Offer one command and hold it until the block takes it. Valid stays
	// high afterwards so back-to-back commands never drop it within a step;
	// an idle cycle, when chosen, lowers it before the next offer.
	task automatic send_command(input ptt_pkg::cmd_t op, input logic [15:0] id_in,
			input logic [15:0] user_in, input logic [31:0] prio_in);
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= op;
		task_id      <= id_in;
		user_id      <= user_in;
		priority_req <= prio_in;
		do @(posedge clk); while (!in_ready);
		update_shadow_table(op, id_in, user_in, prio_in);
	endtask

	// Random command. Ids come mostly from a small hot set so that adds,
	// edits and removes keep hitting present entries; priorities lean on a
	// narrow range so that ties between entries are common.
	task automatic send_random_command();
		int            pick;
		ptt_pkg::cmd_t op;
		logic [15:0]   id_pick;
		logic [31:0]   prio_pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			op = ptt_pkg::CMD_ADD;
		end else if (pick < 60) begin
			op = ptt_pkg::CMD_EDIT;
		end else if (pick < 75) begin
			op = ptt_pkg::CMD_REMOVE;
		end else begin
			op = ptt_pkg::CMD_EXEC;
		end
		if ($urandom_range(0, 99) < 85) begin
			id_pick = hot_ids[$urandom_range(0, HOT_IDS - 1)];
		end else begin
			id_pick = 16'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			prio_pick = $urandom_range(0, 7);
		end else if (pick == 9) begin
			prio_pick = '1;
		end else begin
			prio_pick = $urandom;
		end
		send_command(op, id_pick, 16'($urandom), prio_pick);
	endtask

	// Commands on an empty table: nothing to execute, edit or remove.
	task automatic test_empty_table();
		send_command(ptt_pkg::CMD_EXEC,   16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_command(ptt_pkg::CMD_EDIT,   16'h1234, 16'h0000, 32'h0000_0001);
		send_command(ptt_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000);
	endtask

	// Field extremes: replacing add, edit of present ids, remove of present and absent ids, execute-top.
	task automatic test_add_replace_edit();
		send_command(ptt_pkg::CMD_ADD,    16'h0000, 16'hFFFF, 32'h0000_0000);
		send_command(ptt_pkg::CMD_ADD,    16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
		send_command(ptt_pkg::CMD_ADD,    16'h0000, 16'h5A5A, 32'h8000_0000);
		send_command(ptt_pkg::CMD_EDIT,   16'hFFFF, 16'hFFFF, 32'h0000_0001);
		send_command(ptt_pkg::CMD_EDIT,   16'h0000, 16'h1111, 32'hFFFF_FFFF);
		send_command(ptt_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000);
		send_command(ptt_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000);
		send_command(ptt_pkg::CMD_EXEC,   16'hABCD, 16'hFFFF, 32'h0000_0000);
		send_command(ptt_pkg::CMD_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
	endtask

	// Equal priorities must resolve toward the larger task id.
	task automatic test_priority_ties();
		send_command(ptt_pkg::CMD_ADD, 16'h0005, 16'h0011, 32'd7);
		send_command(ptt_pkg::CMD_ADD, 16'h0009, 16'h0022, 32'd7);
		send_command(ptt_pkg::CMD_ADD, 16'h0003, 16'h0033, 32'd7);
		send_command(ptt_pkg::CMD_ADD, 16'hFFFE, 16'h0044, 32'd6);
		repeat (5) send_command(ptt_pkg::CMD_EXEC, 16'($urandom), 16'($urandom), $urandom);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_command();
	endtask

	// Fill every slot, try to add more, overwrite and edit while full, then
	// execute until one more than the table holds.
	task automatic test_fill_and_drain();
		while (shadow_count < ptt_pkg::NUM_SLOTS) begin
			send_command(ptt_pkg::CMD_ADD, 16'($urandom), 16'($urandom), $urandom);
		end
		repeat (3) send_command(ptt_pkg::CMD_ADD, 16'($urandom), 16'($urandom), $urandom);
		send_command(ptt_pkg::CMD_ADD, shadow_id[$urandom_range(0, ptt_pkg::NUM_SLOTS - 1)],
				16'($urandom), $urandom);
		send_command(ptt_pkg::CMD_EDIT, shadow_id[$urandom_range(0, ptt_pkg::NUM_SLOTS - 1)],
				16'($urandom), $urandom_range(0, 7));
		repeat (ptt_pkg::NUM_SLOTS + 1) begin
			send_command(ptt_pkg::CMD_EXEC, 16'($urandom), 16'($urandom), $urandom);
		end
	endtask

	// The result channel stops for a long stretch while commands keep coming,
	// so the output register fills and the block has to refuse input.
	task automatic test_backpressure();
		hold_requested = 1'b1;
		repeat (30) send_random_command();
	endtask

	// A long run with neither side idling.
	task automatic test_random_quiet();
		no_idle = 1'b1;
		repeat (150) send_random_command();
		no_idle = 1'b0;
	endtask

	// Result side. out_ready drops at random about one time in ten, except during a
	// quiet stretch, and is held low for HOLD_CYCLES when a hold is requested.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_requested = 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Every result transaction is matched against the oldest queued outcome.
	always @(posedge clk) begin : result_check
		outcome_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: result with no command pending, status %0d top_user %0h",
						$time, status, top_user);
				mismatch_count++;
			end else begin
				exp = awaited_outcomes.pop_front();
				if (status !== exp.st) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, exp.st, status);
					mismatch_count++;
				end
				if (top_user !== exp.user) begin
					$display("%0t: top_user mismatch, expected %0h, actual %0h",
							$time, exp.user, top_user);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run if neither channel completes a transaction for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("priority_task_table regression: fail");
				$finish;
			end
		end
	end

	initial begin : test_sequence
		hot_ids[0] = 16'h0000;
		hot_ids[1] = 16'hFFFF;
		for (int i = 2; i < HOT_IDS; i++) begin
			hot_ids[i] = 16'($urandom);
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_add_replace_edit();
		test_priority_ties();
		test_random_mix(220);
		test_fill_and_drain();
		test_backpressure();
		test_random_quiet();
		test_random_mix(100);

		// All commands are in; wait for their results, then a little longer
		// so that any extra result would still be seen by the checker.
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("priority_task_table regression: pass");
		end else begin
			$display("priority_task_table regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/ptt_pkg.sv
src/ptt_cell.sv
src/priority_task_table.sv
verif/tb.sv
